// ----- rtl/erf_pkg.sv -----
// Shared types, codes and constants of the receive address filter.
`default_nettype none

package erf_pkg;

    localparam int ADDRESS_ENTRIES_DEF = 16;
    localparam int HASH_BITS_DEF       = 12;

    localparam int MAC_W         = 48;
    localparam int ENTRY_INDEX_W = 4;
    localparam int TABLE_INDEX_W = 7;
    localparam int HASH_WORD_W   = 32;
    localparam int HASH_BIT_W    = 5;
    localparam int CFG_INDEX_W   = 2;
    localparam int CFG_DATA_W    = 2;

    localparam logic [MAC_W-1:0] STATION_ADDRESS = 48'h0100_004D_4402;

    // Right shift of the address pair per hash offset mode.
    localparam logic [2:0] HASH_SHIFT [4] = '{3'd4, 3'd3, 3'd2, 3'd0};

    typedef enum logic [1:0] {
        OP_CHECK       = 2'd0,
        OP_WRITE_ENTRY = 2'd1,
        OP_WRITE_HASH  = 2'd2
    } op_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_PROMISCUOUS   = 2'd0,
        CFG_MC_PROMISC    = 2'd1,
        CFG_BCAST_ACCEPT  = 2'd2,
        CFG_HASH_MODE     = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic             valid;
        logic [MAC_W-1:0] addr;
    } addr_entry_t;

    localparam addr_entry_t STATION_ENTRY = '{valid: 1'b1, addr: STATION_ADDRESS};

    // Decision terms gathered when a check transaction is taken.
    typedef struct packed {
        logic promisc;
        logic group;
        logic bcast_hit;
        logic mc_promisc;
        logic unicast_hit;
    } check_flags_t;

endpackage

`default_nettype wire

// ----- rtl/erf_hash_mem.sv -----
// Multicast hash table: synchronous word memory with per-word valid bits.
`default_nettype none

module erf_hash_mem
    import erf_pkg::*;
#(
    parameter int WORDS  = 128,
    parameter int WORD_W = 7
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   rd_en,
    input  wire logic [WORD_W-1:0]      rd_word,
    input  wire logic                   wr_en,
    input  wire logic [WORD_W-1:0]      wr_word,
    input  wire logic [HASH_WORD_W-1:0] wr_data,
    output logic      [HASH_WORD_W-1:0] rd_data,
    output logic                        rd_valid
);

    logic [HASH_WORD_W-1:0] mem [WORDS];
    logic [HASH_WORD_W-1:0] rd_data_reg;
    logic [WORDS-1:0]       word_valid_reg;
    logic                   rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_word] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_word];
        end
    end

    // Words never written read back with rd_valid low.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_valid_reg <= '0;
            rd_valid_reg   <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                word_valid_reg[wr_word] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= word_valid_reg[rd_word];
            end
        end
    end

    assign rd_data  = rd_data_reg;
    assign rd_valid = rd_valid_reg;

endmodule

`default_nettype wire

// ----- rtl/erf_addr_table.sv -----
// Individual address table: entry registers with a parallel match.
`default_nettype none

module erf_addr_table
    import erf_pkg::*;
#(
    parameter int ENTRIES = 16
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     wr_en,
    input  wire logic [ENTRY_INDEX_W-1:0] wr_index,
    input  wire logic [MAC_W-1:0]         wr_address,
    input  wire logic                     wr_valid,
    input  wire logic [MAC_W-1:0]         lookup,
    output logic                          hit
);

    addr_entry_t      entry_reg [ENTRIES];
    logic [ENTRIES-1:0] match;

    // Indexes at or above the table depth match no entry and are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ENTRIES; i++)
            begin
                entry_reg[i] <= (i == 0) ? STATION_ENTRY : '0;
            end
        end
        else
        begin
            for (int i = 0; i < ENTRIES; i++)
            begin
                if (wr_en && (wr_index == ENTRY_INDEX_W'(i)))
                begin
                    entry_reg[i] <= '{valid: wr_valid, addr: wr_address};
                end
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            match[i] = entry_reg[i].valid && (entry_reg[i].addr == lookup);
        end
    end

    assign hit = |match;

endmodule

`default_nettype wire

// ----- rtl/ethernet_receive_address_filter.sv -----
// A check transaction passes stage 1, then the output register. One transaction
// per cycle unless the result stalls; the hash memory is read when the transaction
// is taken and a write is visible to the very next transaction. Table writes give
// no result. Reset is asynchronous, active low: control registers clear, entry 0
// holds the station address, hash words read as zero at once.
`default_nettype none

module ethernet_receive_address_filter
    import erf_pkg::*;
#(
    parameter int ADDRESS_ENTRIES = ADDRESS_ENTRIES_DEF,
    parameter int HASH_BITS       = HASH_BITS_DEF
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,

    input  wire logic                     cfg_valid,
    output logic                          cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [CFG_DATA_W-1:0]    cfg_data,

    input  wire logic                     item_valid,
    output logic                          item_ready,
    input  wire logic [1:0]               op,
    input  wire logic [MAC_W-1:0]         address,
    input  wire logic [ENTRY_INDEX_W-1:0] entry_index,
    input  wire logic                     entry_valid,
    input  wire logic [TABLE_INDEX_W-1:0] table_index,
    input  wire logic [HASH_WORD_W-1:0]   table_word,

    output logic                          result_valid,
    input  wire logic                     result_ready,
    output logic                          accept
);

    localparam int HASH_WORDS = (2 ** HASH_BITS) / HASH_WORD_W;
    localparam int WORD_W     = HASH_BITS - HASH_BIT_W;

    logic       promisc_reg;
    logic       mc_promisc_reg;
    logic       bcast_reg;
    logic [1:0] hash_mode_reg;

    logic         s1_valid_reg;
    logic         s1_check_reg;
    check_flags_t s1_flags_reg;
    check_flags_t flags_next;
    logic [HASH_BIT_W-1:0] s1_bit_reg;

    logic result_valid_reg;
    logic accept_reg;

    logic item_accept;
    logic s1_adv;
    logic is_check;
    logic unicast_hit;
    logic [15:0] pair_shifted;
    logic [HASH_BITS-1:0] hash_idx;
    logic [HASH_WORD_W-1:0] rd_data;
    logic rd_valid;
    logic decision;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            promisc_reg    <= 1'b0;
            mc_promisc_reg <= 1'b0;
            bcast_reg      <= 1'b0;
            hash_mode_reg  <= 2'd0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_reg_t'(cfg_index))
                CFG_PROMISCUOUS:  promisc_reg    <= cfg_data[0];
                CFG_MC_PROMISC:   mc_promisc_reg <= cfg_data[0];
                CFG_BCAST_ACCEPT: bcast_reg      <= cfg_data[0];
                CFG_HASH_MODE:    hash_mode_reg  <= cfg_data[1:0];
                default: ;
            endcase
        end
    end

    assign item_accept = item_valid && item_ready;
    assign s1_adv      = s1_valid_reg && (!result_valid_reg || result_ready);
    assign item_ready  = !s1_valid_reg || s1_adv;
    assign is_check    = (op == OP_CHECK);

    assign pair_shifted = address[47:32] >> HASH_SHIFT[hash_mode_reg];
    assign hash_idx     = pair_shifted[HASH_BITS-1:0];

    erf_addr_table #(
        .ENTRIES (ADDRESS_ENTRIES)
    ) u_addr_table (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr_en      (item_accept && (op == OP_WRITE_ENTRY)),
        .wr_index   (entry_index),
        .wr_address (address),
        .wr_valid   (entry_valid),
        .lookup     (address),
        .hit        (unicast_hit)
    );

    erf_hash_mem #(
        .WORDS  (HASH_WORDS),
        .WORD_W (WORD_W)
    ) u_hash_mem (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_en    (item_accept && is_check),
        .rd_word  (hash_idx[HASH_BITS-1:HASH_BIT_W]),
        .wr_en    (item_accept && (op == OP_WRITE_HASH)),
        .wr_word  (table_index[WORD_W-1:0]),
        .wr_data  (table_word),
        .rd_data  (rd_data),
        .rd_valid (rd_valid)
    );

    always_comb
    begin
        flags_next.promisc     = promisc_reg;
        flags_next.group       = address[0];
        flags_next.bcast_hit   = bcast_reg && (address == {MAC_W{1'b1}});
        flags_next.mc_promisc  = mc_promisc_reg;
        flags_next.unicast_hit = unicast_hit;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_check_reg <= 1'b0;
        end
        else if (item_accept)
        begin
            s1_valid_reg <= 1'b1;
            s1_check_reg <= is_check;
        end
        else if (s1_adv)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_accept)
        begin
            s1_flags_reg <= flags_next;
            s1_bit_reg   <= hash_idx[HASH_BIT_W-1:0];
        end
    end

    assign decision = s1_flags_reg.promisc
        || (s1_flags_reg.group && (s1_flags_reg.bcast_hit || s1_flags_reg.mc_promisc
                                   || (rd_valid && rd_data[s1_bit_reg])))
        || (!s1_flags_reg.group && s1_flags_reg.unicast_hit);

    // Advance the stage into the output register; drop table writes there.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (s1_adv)
        begin
            result_valid_reg <= s1_check_reg;
        end
        else if (result_ready)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            accept_reg <= decision;
        end
    end

    assign result_valid = result_valid_reg;
    assign accept       = accept_reg;

endmodule

`default_nettype wire

// ----- rtl/erf_checker.sv -----
// Port-level checks of the receive address filter, bound to the top level.
`default_nettype none

module erf_checker
    import erf_pkg::*;
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       item_valid,
    input wire logic       item_ready,
    input wire logic [1:0] op,
    input wire logic       result_valid,
    input wire logic       result_ready,
    input wire logic       accept
);

    // A stalled result holds its value.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(accept))
    else $error("stalled result changed");

    // Input stalls only behind a pending result.
    assert property (@(posedge clk) disable iff (!rst_n)
        !item_ready |-> result_valid)
    else $error("input stalled with no result pending");

    // A check transaction yields a result once it has passed stage 1 and the output register.
    assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready && (op == OP_CHECK) |-> ##2 result_valid)
    else $error("check transaction gave no result");

    // A table write into an empty pipeline yields no result.
    assert property (@(posedge clk) disable iff (!rst_n)
        $past(!(item_valid && item_ready)) && !result_valid
        && item_valid && item_ready && (op != OP_CHECK) |=> !result_valid)
    else $error("result from a table write");

endmodule

bind ethernet_receive_address_filter erf_checker u_erf_checker (.*);

`default_nettype wire
